// ===== rtl/sbdc_pkg.sv =====
package sbdc_pkg;

  localparam int NumDigits = 21;
  localparam int ValueBits = 64;
  localparam int DigitBits = 4;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  typedef logic [DigitBits-1:0] bcd_digit_t;
  typedef bcd_digit_t [NumDigits-1:0] bcd_word_t;

  // handoff from the converter to the character emitter
  typedef struct packed {
    logic      valid;
    logic      neg;
    bcd_word_t digits;
  } sbdc_conv_t;

  // add 3 to a digit of 5 or more before it is doubled
  function automatic bcd_digit_t dabble_adjust(input bcd_digit_t d);
    bcd_digit_t r;
    r = (d >= 4'd5) ? bcd_digit_t'(d + 4'd3) : d;
    return r;
  endfunction

endpackage

// ===== rtl/sbdc_dabble.sv =====
module sbdc_dabble (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [63:0]                value,
  output logic                       busy,
  output sbdc_pkg::sbdc_conv_t       conv
);
  import sbdc_pkg::*;

  localparam int StepBits = $clog2(ValueBits);
  localparam logic [StepBits-1:0] LastStep = StepBits'(ValueBits - 1);

  logic                 run;
  logic                 done;
  logic                 neg;
  logic [StepBits-1:0]  step;
  logic [ValueBits-1:0] mag;
  bcd_word_t            digits;
  bcd_word_t            digits_next;
  logic [NumDigits*DigitBits-1:0] adj;

  // adjust every digit, then shift the whole chain left, magnitude MSB in
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      adj[k*DigitBits +: DigitBits] = dabble_adjust(digits[k]);
    end
    digits_next = bcd_word_t'({adj[NumDigits*DigitBits-2:0], mag[ValueBits-1]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run  <= 1'b1;
        step <= '0;
        neg  <= value[ValueBits-1];
        // the most negative value negates to itself, which reads as 2^63 unsigned
        mag  <= value[ValueBits-1] ? (~value + 64'd1) : value;
        digits <= '0;
      end else if (run) begin
        digits <= digits_next;
        mag    <= {mag[ValueBits-2:0], 1'b0};
        step   <= step + 1'b1;
        if (step == LastStep) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign busy        = run | done;
  assign conv.valid  = done;
  assign conv.neg    = neg;
  assign conv.digits = digits;

endmodule

// ===== rtl/sbdc_emit.sv =====
module sbdc_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  sbdc_pkg::sbdc_conv_t  conv,
  output logic                  busy,
  output logic                  strobe,
  output logic [7:0]            character,
  output logic                  last
);
  import sbdc_pkg::*;

  localparam int LeftBits = $clog2(NumDigits + 1);
  localparam logic [LeftBits-1:0] OneLeft = LeftBits'(1);

  logic                active;
  logic                neg_pend;
  logic                lead;
  logic [LeftBits-1:0] left;
  bcd_word_t           digits;
  bcd_digit_t          top;

  assign top = digits[NumDigits-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (conv.valid) begin
        active   <= 1'b1;
        neg_pend <= conv.neg;
        lead     <= 1'b1;
        left     <= LeftBits'(NumDigits);
        digits   <= conv.digits;
      end else if (active) begin
        if (neg_pend) begin
          strobe    <= 1'b1;
          character <= CharMinus;
          last      <= 1'b0;
          neg_pend  <= 1'b0;
        end else begin
          digits <= bcd_word_t'({digits[NumDigits-2:0], bcd_digit_t'(0)});
          left   <= left - 1'b1;
          // drop leading zeros, but always keep the final digit
          if (!(lead && top == '0 && left != OneLeft)) begin
            strobe    <= 1'b1;
            character <= CharZero | {4'd0, top};
            last      <= (left == OneLeft);
            lead      <= 1'b0;
          end
          if (left == OneLeft) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  assign busy = active;

endmodule

// ===== rtl/signed_binary_to_decimal_chars_unit.sv =====
// Signed 64-bit integer to decimal ASCII text.
//
// Command channel: drive value and raise start; the beat is taken at the
// rising edge where start is high and busy is low. busy stays high until
// the text of that value has been fully sent.
// Result channel: one character per beat on character/last, marked by
// strobe for exactly one cycle. The first beat is '-' for a negative value,
// then the digits with leading zeros dropped; at least one digit is always
// sent, and last flags the final character. There is no terminator.
// The receiver cannot stall: every strobe beat is taken as it appears.
// Timing: the converter makes one double-dabble shift per cycle, one for
// each of the 64 magnitude bits, then hands the digits to the emitter through
// a register. The emitter walks the 21 BCD digits one per cycle (skipped
// leading zeros still take their step), after a separate step for the sign
// when negative. The next start is taken in the cycle the last character
// is on the ports.
// Reset (rst, synchronous) drops any value in progress and clears strobe
// and busy.
module signed_binary_to_decimal_chars_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        busy,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);
  import sbdc_pkg::*;

  logic       conv_busy;
  logic       emit_busy;
  logic       load;
  sbdc_conv_t conv;

  // take a command beat only when both stages are free
  assign load = start & ~busy;
  assign busy = conv_busy | emit_busy;

  // serial binary-to-BCD conversion
  sbdc_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .value (value),
    .busy  (conv_busy),
    .conv  (conv)
  );

  // digit-serial character output
  sbdc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .conv      (conv),
    .busy      (emit_busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

// ===== rtl/sbdc_checker.sv =====
module sbdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [7:0]  character,
  input logic        last
);
  import sbdc_pkg::*;

  // an accepted command holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // the conversion runs before any text: no beat right after an accept
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe) else $error("strobe right after accept");

  // text still pending keeps the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("idle before last character");

  // the final character is always a digit
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> (character >= CharZero && character <= CharZero + 8'd9))
    else $error("last character not a digit");

  // a sign is always followed by a digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && character == CharMinus |-> !last) else $error("sign flagged last");

endmodule

bind signed_binary_to_decimal_chars_unit sbdc_checker u_sbdc_checker (.*);
